// ----- hdl/vlcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlcb_pkg
// Constants, register indexes and tables for the vertex light color blend.
// ----------------------------------------------------------------------------
package vlcb_pkg;

	typedef enum logic [1:0] {
		REG_RATIO = 2'd0,
		REG_AMB_R = 2'd1,
		REG_AMB_G = 2'd2,
		REG_AMB_B = 2'd3
	} reg_idx_t;

	localparam int unsigned RATIO_W = 10;
	localparam int unsigned TINT_W  = 19;
	localparam int unsigned LEVEL_W = 28;

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1000);

	// artificial tint, 1.04 in Q2.16
	localparam int ART_TINT = 68157;

	// ratio offset that keeps the red/green tint numerator positive
	localparam logic [10:0] RG_BIAS = 11'd960;
	// reciprocal of 125 for a 31-bit shift, applied after a 13-bit pre-shift
	localparam logic [24:0] RECIP_125 = 25'd17179870;
	// reciprocal of 3125 for a 40-bit shift, applied after an 11-bit pre-shift
	localparam logic [28:0] RECIP_3125 = 29'd351843721;
	// reciprocal of 255 for a 34-bit shift
	localparam logic [26:0] RECIP_255 = 27'd67372037;

	localparam logic [16:0] SUN_B_BASE = 17'd7800;
	localparam logic [16:0] SUN_B_MUL  = 17'd98;

	// sun red/green tint minus the artificial tint: product>>18 - 65536 - ART
	localparam logic signed [TINT_W-1:0] RG_DIFF_OFS = TINT_W'(65536 + ART_TINT);
	localparam logic signed [TINT_W-1:0] B_DIFF_OFS  = TINT_W'(ART_TINT);

	// 255 * 2^17 keeps the mix numerator positive before the reciprocal
	localparam logic signed [27:0] MIX_OFS = 28'sd33423360;
	// undo the 2^17 offset and add back the artificial tint
	localparam logic signed [19:0] MIX_BACK = 20'sd62915;

	// dark boost by bits [7:3] of the level sum over 2^16:
	// entry k is the dark table at index floor(k / 3)
	localparam logic [2:0] DARK_BY_T8 [32] = '{
		3'd1, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd6, 3'd6,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5,
		3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3,
		3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0
	};

	typedef struct packed {
		logic [15:0] rem;
		logic [7:0]  quo;
		logic [8:0]  sum;
		logic [7:0]  bright;
		logic        zero;
	} div_t;

	// two restoring quotient bits, top bit at position sh
	function automatic div_t div_step2(input div_t d, input logic [2:0] sh);
		div_t r;
		logic [15:0] den;
		logic [2:0] pos;
		r = d;
		for (int k = 0; k < 2; k++) begin
			pos = sh - 3'(k);
			den = 16'(r.sum) << pos;
			if (r.rem >= den) begin
				r.rem = r.rem - den;
				r.quo[pos] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] clamp_u8(input logic signed [11:0] v);
		logic [7:0] r;
		if (v[11])
			r = 8'd0;
		else if (|v[10:8])
			r = 8'd255;
		else
			r = v[7:0];
		return r;
	endfunction

endpackage

// ----- hdl/vertex_light_color_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_light_color_blend
// Per-vertex light word to encoded light color and clamped RGB, 12-stage
// pipeline with a 4-stage pipelined divider for the sun share.
// ----------------------------------------------------------------------------
//  channel   ports                                         handshake
//  request   light_word, emissive_level                    start && !busy
//  result    sun_share, brightness, red/green/blue_out     done, one cycle
//  config    psel penable pwrite paddr pwdata prdata       pready tied high
//
//  One request per cycle while busy is low; each result is registered through
//  stages s1 to s12. busy is high after reset and after a write of
//  day_night_ratio, while the tint pipeline recomputes the sun tints.
//  The result side cannot stall, so the pipeline always advances.
// ----------------------------------------------------------------------------
module vertex_light_color_blend
	import vlcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] light_word,
	input  logic [7:0]  emissive_level,
	output logic        done,
	output logic [7:0]  sun_share,
	output logic [7:0]  brightness,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [RATIO_W-1:0] ratio_q;
	logic [7:0] amb_r_q, amb_g_q, amb_b_q;
	logic [1:0] refresh_q;
	logic cfg_wr, ratio_wr, accept;
	reg_idx_t cfg_idx;

	logic [10:0] rp_q;
	logic [16:0] nb_q;
	logic [35:0] prg_q;
	logic [45:0] pb_q;
	logic signed [TINT_W-1:0] drg_q, db_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	logic [7:0] night_s1, day_s1;
	logic [7:0] day_s2;
	logic [8:0] sum_s2;
	div_t div_in, div_s3, div_s4, div_s5, div_s6;
	logic [7:0] share_s7, bright_s7, share_s8, bright_s8, share_s9, bright_s9;
	logic [7:0] share_s10, bright_s10, share_s11, bright_s11;
	logic signed [27:0] prod_rg_s7, prod_b_s7;
	logic [52:0] p_rg_s8, p_b_s8;
	logic signed [19:0] mix_rg_s9, mix_b_s9;
	logic signed [LEVEL_W-1:0] c_rg_s10, c_b_s10;
	logic signed [11:0] lvl_rg_s11, lvl_b_s11;
	logic [2:0] boost_s11;
	logic [7:0] share_s12, bright_s12, red_s12, green_s12, blue_s12;

	logic [10:0] night_add;
	logic [27:0] y_rg, y_b;
	logic signed [29:0] lsum;
	logic [2:0] boost;
	logic signed [9:0] bright2;
	logic signed [29:0] c_rg_full, c_b_full;
	logic signed [11:0] r_sum, g_sum, b_sum;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	assign pready   = 1'b1;
	assign cfg_idx  = reg_idx_t'(paddr[3:2]);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign ratio_wr = cfg_wr && (cfg_idx == REG_RATIO);
	assign busy     = (refresh_q != 2'd0);
	assign accept   = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q   <= RATIO_RESET;
			amb_r_q   <= 8'd0;
			amb_g_q   <= 8'd0;
			amb_b_q   <= 8'd0;
			refresh_q <= 2'd3;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_RATIO: ratio_q <= pwdata[RATIO_W-1:0];
					REG_AMB_R: amb_r_q <= pwdata[7:0];
					REG_AMB_G: amb_g_q <= pwdata[7:0];
					REG_AMB_B: amb_b_q <= pwdata[7:0];
				endcase
			end
			if (ratio_wr)
				refresh_q <= 2'd3;
			else if (refresh_q != 2'd0)
				refresh_q <= refresh_q - 2'd1;
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_RATIO: prdata = 32'(ratio_q);
			REG_AMB_R: prdata = 32'(amb_r_q);
			REG_AMB_G: prdata = 32'(amb_g_q);
			REG_AMB_B: prdata = 32'(amb_b_q);
		endcase
	end

	// ------------------------------------------------------------------
	// sun tints minus the artificial tint, recomputed continuously
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		rp_q  <= 11'(ratio_q) + RG_BIAS;
		nb_q  <= 17'(ratio_q) * SUN_B_MUL + SUN_B_BASE;
		prg_q <= 36'(rp_q) * 36'(RECIP_125);
		pb_q  <= 46'(nb_q) * 46'(RECIP_3125);
		drg_q <= $signed({1'b0, prg_q[35:18]}) - RG_DIFF_OFS;
		db_q  <= $signed({2'b0, pb_q[45:29]}) - B_DIFF_OFS;
	end

	// ------------------------------------------------------------------
	// request pipeline
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {accept, v_s1, v_s2, v_s3, v_s4, v_s5};
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= {v_s6, v_s7, v_s8, v_s9, v_s10, v_s11};
		end
	end

	assign night_add = 11'(light_word[15:8]) + ((11'(emissive_level) * 11'd5) >> 1);

	always_comb begin
		div_in.rem    = {day_s2, 8'd0} - 16'(day_s2);
		div_in.quo    = 8'd0;
		div_in.sum    = sum_s2;
		div_in.bright = sum_s2[8:1];
		div_in.zero   = (sum_s2 == 9'd0);
	end

	assign y_rg = 28'(prod_rg_s7 + MIX_OFS);
	assign y_b  = 28'(prod_b_s7 + MIX_OFS);

	assign bright2   = $signed({1'b0, bright_s9, 1'b0});
	assign c_rg_full = bright2 * mix_rg_s9;
	assign c_b_full  = bright2 * mix_b_s9;

	assign lsum = {{1{c_rg_s10[LEVEL_W-1]}}, c_rg_s10, 1'b0}
		+ {{2{c_b_s10[LEVEL_W-1]}}, c_b_s10};

	always_comb begin
		if (lsum[29])
			boost = DARK_BY_T8[0];
		else if (|lsum[28:24])
			boost = 3'd0;
		else
			boost = DARK_BY_T8[lsum[23:19]];
	end

	assign r_sum = lvl_rg_s11 + $signed({4'b0, amb_r_q});
	assign g_sum = lvl_rg_s11 + $signed({4'b0, amb_g_q});
	assign b_sum = lvl_b_s11 + $signed({9'b0, boost_s11}) + $signed({4'b0, amb_b_q});

	always_ff @(posedge clk) begin
		// saturate night, take night from day
		night_s1 <= (night_add > 11'd255) ? 8'd255 : night_add[7:0];
		day_s1   <= light_word[7:0];

		day_s2 <= (day_s1 < night_s1) ? 8'd0 : day_s1 - night_s1;
		sum_s2 <= 9'((day_s1 < night_s1) ? night_s1 : day_s1);

		// share = day * 255 / sum, two bits per stage
		div_s3 <= div_step2(div_in, 3'd7);
		div_s4 <= div_step2(div_s3, 3'd5);
		div_s5 <= div_step2(div_s4, 3'd3);
		div_s6 <= div_step2(div_s5, 3'd1);

		share_s7   <= div_s6.zero ? 8'd0 : div_s6.quo;
		bright_s7  <= div_s6.bright;
		prod_rg_s7 <= 28'($signed({1'b0, div_s6.zero ? 8'd0 : div_s6.quo})) * 28'(drg_q);
		prod_b_s7  <= 28'($signed({1'b0, div_s6.zero ? 8'd0 : div_s6.quo})) * 28'(db_q);

		share_s8  <= share_s7;
		bright_s8 <= bright_s7;
		p_rg_s8   <= 53'(y_rg[25:0]) * 53'(RECIP_255);
		p_b_s8    <= 53'(y_b[25:0]) * 53'(RECIP_255);

		share_s9  <= share_s8;
		bright_s9 <= bright_s8;
		mix_rg_s9 <= $signed({1'b0, p_rg_s8[52:34]}) - MIX_BACK;
		mix_b_s9  <= $signed({1'b0, p_b_s8[52:34]}) - MIX_BACK;

		share_s10  <= share_s9;
		bright_s10 <= bright_s9;
		c_rg_s10   <= LEVEL_W'(c_rg_full);
		c_b_s10    <= LEVEL_W'(c_b_full);

		share_s11  <= share_s10;
		bright_s11 <= bright_s10;
		lvl_rg_s11 <= c_rg_s10[LEVEL_W-1:16];
		lvl_b_s11  <= c_b_s10[LEVEL_W-1:16];
		boost_s11  <= boost;

		share_s12  <= share_s11;
		bright_s12 <= bright_s11;
		red_s12    <= clamp_u8(r_sum);
		green_s12  <= clamp_u8(g_sum);
		blue_s12   <= clamp_u8(b_sum);
	end

	assign done       = v_s12;
	assign sun_share  = share_s12;
	assign brightness = bright_s12;
	assign red_out    = red_s12;
	assign green_out  = green_s12;
	assign blue_out   = blue_s12;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##12 done)
		else $error("accepted request did not produce a result");

	a_ratio_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ratio_wr |=> busy)
		else $error("ratio write did not raise busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(ratio_wr))
		else $error("busy rose without a ratio write");
`endif

endmodule
